// ===== rtl/rfo_pkg.sv =====
// Shared types and codes for the ring FIFO with overflow modes.
package rfo_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CNT_W          = 6;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_RESIZE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK          = 3'd0,
    RS_DROPPED     = 3'd1,
    RS_FULL_BLOCK  = 3'd2,
    RS_EMPTY       = 3'd3,
    RS_EMPTY_BLOCK = 3'd4,
    RS_DISCARD     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_SHIFT,
    OP_ROTATE
  } chain_op_t;

  typedef enum logic {
    REG_WRITE_FULL_MODE = 1'b0,
    REG_READ_EMPTY_MODE = 1'b1
  } reg_idx_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    chain_op_t        op;
    logic [CNT_W-1:0] count;
  } chain_ctl_t;

endpackage

// ===== rtl/rfo_cell.sv =====
// One storage cell of the FIFO chain; cell 0 holds the oldest element.
module rfo_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = rfo_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  rfo_pkg::chain_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0]   nbr_data,
  input  logic [DATA_WIDTH-1:0]   wrap_data,
  input  logic [DATA_WIDTH-1:0]   wr_data,
  output logic [DATA_WIDTH-1:0]   data_q
);
  import rfo_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic [CNT_W-1:0]      last_idx;

  assign last_idx = ctl.count - CNT_W'(1);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_WRITE: begin
        if (ctl.count == MY_IDX) data_nxt = wr_data;
      end
      OP_SHIFT: data_nxt = nbr_data;
      // rotate only the occupied part: oldest wraps to the tail
      OP_ROTATE: begin
        if (MY_IDX < last_idx)       data_nxt = nbr_data;
        else if (MY_IDX == last_idx) data_nxt = wrap_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== rtl/ring_fifo_with_overflow_modes_top.sv =====
// Top level of the ring FIFO with runtime capacity and overflow modes.
//
// Usage:
//   Commands enter on start/in_command with in_write_data and in_new_capacity;
//   an item is taken when start is high and busy is low. Each result appears on
//   the out_ ports for one cycle, flagged by out_valid; the receiver cannot stall
//   and must take every result in the cycle it is shown.
//   Write, read and the unused command give one result in the cycle after the
//   item is taken, and busy stays low, so one of these items per cycle is taken.
//   Resize rotates the N stored elements once through the cell chain, one step
//   per cycle, sending each discarded element out as it passes cell 0.
//   busy stays high through the rotation and the done state that follows; the discards
//   show while busy is still high and the completion result once busy is low again.
//   Config writes (cfg_valid, cfg_index, cfg_data) are always ready and take
//   effect at once; write them only while the block is idle.
//   Reset (rst_n low, synchronous) empties the FIFO, sets capacity to DEPTH,
//   write_full_mode to 0 and read_empty_mode to 1. Cell contents are not reset.
//   Storage is a chain of DEPTH cells, oldest element in cell 0; a read shifts
//   the whole chain down by one.
module ring_fifo_with_overflow_modes_top #(
  parameter int DEPTH      = rfo_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rfo_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rfo_pkg::CMD_W-1:0]     in_command,
  input  logic [DATA_WIDTH-1:0]         in_write_data,
  input  logic [rfo_pkg::CNT_W-1:0]     in_new_capacity,
  output logic                          out_valid,
  output logic [rfo_pkg::STATUS_W-1:0]  out_status,
  output logic [DATA_WIDTH-1:0]         out_read_data,
  output logic [rfo_pkg::CNT_W-1:0]     out_fill_count,
  output logic                          out_is_empty,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic                          cfg_data
);
  import rfo_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] keep_r, keep_nxt;
  logic [CNT_W-1:0] ncap_r, ncap_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             wfull_mode_r;
  logic             rempty_mode_r;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]      out_fill_r, out_fill_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  cmd_t                  cmd;
  logic [CNT_W-1:0]      ncap_sat;
  chain_ctl_t            ctl;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  assign accept    = start && (state_r == S_IDLE);
  assign cmd       = cmd_t'(in_command);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Capacity saturates to 1..DEPTH.
  always_comb begin
    if (in_new_capacity == '0)        ncap_sat = CNT_W'(1);
    else if (in_new_capacity > DEPTH_C) ncap_sat = DEPTH_C;
    else                              ncap_sat = in_new_capacity;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NBR = (i == DEPTH - 1) ? 0 : i + 1;
    rfo_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .nbr_data  (cell_q[NBR]),
      .wrap_data (cell_q[0]),
      .wr_data   (in_write_data),
      .data_q    (cell_q[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && cmd == CMD_RESIZE) begin
          state_nxt = (count_r == '0) ? S_DONE : S_ROT;
        end
      end
      S_ROT: begin
        if (step_r == count_r - CNT_W'(1)) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    keep_nxt       = keep_r;
    ncap_nxt       = ncap_r;
    step_nxt       = step_r;
    ctl.op         = OP_HOLD;
    ctl.count      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = RS_OK;
    out_data_nxt   = '0;
    out_fill_nxt   = count_r;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (cmd)
            CMD_WRITE: begin
              if (count_r >= cap_r) begin
                out_status_nxt = wfull_mode_r ? RS_DROPPED : RS_FULL_BLOCK;
              end else begin
                ctl.op       = OP_WRITE;
                count_nxt    = count_r + CNT_W'(1);
                out_fill_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_READ: begin
              if (count_r == '0) begin
                out_status_nxt = rempty_mode_r ? RS_EMPTY : RS_EMPTY_BLOCK;
              end else begin
                ctl.op       = OP_SHIFT;
                out_data_nxt = cell_q[0];
                count_nxt    = count_r - CNT_W'(1);
                out_fill_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_RESIZE: begin
              out_valid_nxt = 1'b0;
              ncap_nxt      = ncap_sat;
              keep_nxt      = (count_r < ncap_sat) ? count_r : ncap_sat;
              step_nxt      = '0;
            end
            default: out_status_nxt = RS_OK;
          endcase
        end
      end
      S_ROT: begin
        // cell 0 holds logical entry step_r; entries past keep are dropped
        ctl.op   = OP_ROTATE;
        step_nxt = step_r + CNT_W'(1);
        if (step_r >= keep_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = RS_DISCARD;
          out_data_nxt   = cell_q[0];
          out_fill_nxt   = keep_r;
          out_last_nxt   = 1'b0;
        end
      end
      S_DONE: begin
        count_nxt     = keep_r;
        cap_nxt       = ncap_r;
        out_valid_nxt = 1'b1;
        out_fill_nxt  = keep_r;
      end
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      cap_r         <= DEPTH_C;
      wfull_mode_r  <= 1'b0;
      rempty_mode_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_WRITE_FULL_MODE: wfull_mode_r  <= cfg_data;
          REG_READ_EMPTY_MODE: rempty_mode_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    keep_r       <= keep_nxt;
    ncap_r       <= ncap_nxt;
    step_r       <= step_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_data  = out_data_r;
  assign out_fill_count = out_fill_r;
  assign out_is_empty   = (out_fill_r == '0);
  assign out_last       = out_last_r;

endmodule

// ===== sim/ring_fifo_with_overflow_modes_checker.sv =====
// Checker for the ring FIFO: mirrors its state, predicts each result and compares.
module ring_fifo_with_overflow_modes_checker
  import rfo_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [DATA_WIDTH-1:0] in_write_data,
  input  logic [CNT_W-1:0]      in_new_capacity,
  input  logic                  out_valid,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [DATA_WIDTH-1:0] out_read_data,
  input  logic [CNT_W-1:0]      out_fill_count,
  input  logic                  out_is_empty,
  input  logic                  out_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic                  cfg_data,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = $clog2(DEPTH);

  typedef struct packed {
    status_t               status;
    logic [DATA_WIDTH-1:0] data;
    logic [CNT_W-1:0]      fill;
    logic                  empty;
    logic                  last;
  } fifo_result_t;

  // mirrored FIFO state
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  int unsigned           head;
  int unsigned           fill;
  int unsigned           cap;
  logic                  drop_when_full;
  logic                  report_when_empty;

  fifo_result_t          expected_q[$];
  fifo_result_t          want;
  int unsigned           err_cnt;
  int unsigned           result_idx;

  function automatic int unsigned slot_of(int unsigned ofs);
    return (head + ofs) % cap;
  endfunction

  // fill and empty always reflect the state at the end of the command
  task automatic push_result(status_t st, logic [DATA_WIDTH-1:0] d, logic lst);
    fifo_result_t r;
    r.status = st;
    r.data   = d;
    r.fill   = CNT_W'(fill);
    r.empty  = (fill == 0);
    r.last   = lst;
    expected_q.push_back(r);
  endtask

  task automatic apply_command(cmd_t cmd, logic [DATA_WIDTH-1:0] d, logic [CNT_W-1:0] nc);
    logic [DATA_WIDTH-1:0] moved [DEPTH];
    logic [DATA_WIDTH-1:0] popped;
    int unsigned           new_cap;
    int unsigned           keep;
    int unsigned           old_fill;
    int unsigned           i;
    case (cmd)
      CMD_WRITE: begin
        if (fill >= cap) begin
          push_result(drop_when_full ? RS_DROPPED : RS_FULL_BLOCK, '0, 1'b1);
        end else begin
          ring[IW'(slot_of(fill))] = d;
          fill++;
          push_result(RS_OK, '0, 1'b1);
        end
      end
      CMD_READ: begin
        if (fill == 0) begin
          push_result(report_when_empty ? RS_EMPTY : RS_EMPTY_BLOCK, '0, 1'b1);
        end else begin
          popped = ring[IW'(head)];
          head   = slot_of(1);
          fill--;
          push_result(RS_OK, popped, 1'b1);
        end
      end
      CMD_RESIZE: begin
        new_cap = 32'(nc);
        if (new_cap == 0) new_cap = 1;
        if (new_cap > DEPTH) new_cap = DEPTH;
        keep     = (fill < new_cap) ? fill : new_cap;
        old_fill = fill;
        for (i = 0; i < keep; i++) moved[IW'(i)] = ring[IW'(slot_of(i))];
        fill = keep;
        // overflow beyond the new capacity leaves oldest first
        for (i = keep; i < old_fill; i++)
          push_result(RS_DISCARD, ring[IW'(slot_of(i))], 1'b0);
        ring = moved;
        head = 0;
        cap  = new_cap;
        push_result(RS_OK, '0, 1'b1);
      end
      default: begin
        push_result(RS_OK, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head              = 0;
      fill              = 0;
      cap               = DEPTH;
      drop_when_full    = 1'b0;
      report_when_empty = 1'b1;
      expected_q.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        result_idx++;
        if (expected_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: result %0d with nothing expected: status %0d data %h",
                     $time, result_idx, out_status, out_read_data);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status || out_read_data !== want.data ||
              out_fill_count !== want.fill || out_is_empty !== want.empty ||
              out_last !== want.last) begin
            if (err_cnt < 10)
              $display({"%0t: result %0d mismatch: expected st %0d data %h fill %0d ",
                        "empty %0b last %0b, got st %0d data %h fill %0d empty %0b last %0b"},
                       $time, result_idx, want.status, want.data, want.fill, want.empty,
                       want.last, out_status, out_read_data, out_fill_count,
                       out_is_empty, out_last);
            err_cnt++;
          end
        end
      end
      // an item taken at this edge still sees the old modes
      if (start && !busy) apply_command(cmd_t'(in_command), in_write_data, in_new_capacity);
      if (cfg_valid && cfg_ready) begin
        if (reg_idx_t'(cfg_index) == REG_WRITE_FULL_MODE) drop_when_full = cfg_data;
        else report_when_empty = cfg_data;
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_q.size();
  end

endmodule

// ===== sim/ring_fifo_with_overflow_modes_top_test.sv =====
// Testbench top for the ring FIFO: drives commands and mode writes, reports the verdict.
module ring_fifo_with_overflow_modes_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfo_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [31:0]         in_write_data;
  logic [CNT_W-1:0]    in_new_capacity;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [31:0]         out_read_data;
  logic [CNT_W-1:0]    out_fill_count;
  logic                out_is_empty;
  logic                out_last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic                cfg_data;
  int unsigned         mismatches;
  int unsigned         outstanding;

  // idle bursts on the command side; switched off for the closing phases
  bit                  gaps_on;

  // write share of the random command mix, one entry per phase:
  // high shares push the FIFO to full, low ones drain it to empty
  int unsigned         write_pct [8] = '{50, 85, 20, 70, 40, 85, 30, 60};

  ring_fifo_with_overflow_modes_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_write_data   (in_write_data),
    .in_new_capacity (in_new_capacity),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_fill_count  (out_fill_count),
    .out_is_empty    (out_is_empty),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  ring_fifo_with_overflow_modes_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_write_data   (in_write_data),
    .in_new_capacity (in_new_capacity),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_fill_count  (out_fill_count),
    .out_is_empty    (out_is_empty),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Slowest correct run is about 230 items, each a 32-entry resize plus the longest
  // idle gap: roughly 120 us. 2 ms is ample.
  initial begin
    #2_000_000;
    $display("** ring_fifo_with_overflow_modes_top: FAILED **");
    $finish;
  end

  // Present one item and hold it until the block takes it. Called right after
  // a rising edge; start stays high across back-to-back items.
  task automatic issue(cmd_t cmd, logic [31:0] d, logic [CNT_W-1:0] nc);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_write_data   <= d;
    in_new_capacity <= nc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop issuing and wait until every predicted result has come out.
  // outstanding is registered in the checker, so it lags the checker's queue.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Both mode registers, back to back, valid held high across the pair.
  task automatic write_modes(logic full_drop, logic empty_report);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WRITE_FULL_MODE;
    cfg_data  <= full_drop;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_READ_EMPTY_MODE;
    cfg_data  <= empty_report;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned      pick;
    logic [CNT_W-1:0] nc;
    cmd_t             cmd;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_WRITE;
    in_write_data   = '0;
    in_new_capacity = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_WRITE_FULL_MODE;
    cfg_data        = 1'b0;
    gaps_on         = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset modes: refuse when full, report when empty.
    issue(CMD_READ,   32'h0000_0000, 6'd0);   // read on empty
    issue(CMD_WRITE,  32'h0000_0000, 6'd0);
    issue(CMD_WRITE,  32'hFFFF_FFFF, 6'd63);
    issue(CMD_WRITE,  32'hA5A5_A5A5, 6'd0);
    issue(CMD_WRITE,  32'h5A5A_5A5A, 6'd0);
    issue(CMD_NONE,   32'hFFFF_FFFF, 6'd63);  // unused command: no state change
    issue(CMD_READ,   32'hFFFF_FFFF, 6'd63);
    issue(CMD_RESIZE, 32'h0000_0000, 6'd0);   // zero saturates to one, two discards
    issue(CMD_WRITE,  32'h1234_5678, 6'd0);   // full at capacity one: refused
    issue(CMD_RESIZE, 32'h0000_0000, 6'd63);  // above depth saturates
    issue(CMD_WRITE,  32'h8765_4321, 6'd0);
    issue(CMD_RESIZE, 32'h0000_0000, 6'd32);  // exactly depth, nothing discarded
    issue(CMD_READ,   32'h0000_0000, 6'd0);
    issue(CMD_READ,   32'h0000_0000, 6'd0);
    issue(CMD_READ,   32'h0000_0000, 6'd0);   // empty again
    settle();

    // Opposite modes: drop when full, refuse when empty.
    write_modes(1'b1, 1'b0);
    issue(CMD_RESIZE, 32'h0000_0000, 6'd2);
    issue(CMD_WRITE,  32'hDEAD_BEEF, 6'd0);
    issue(CMD_WRITE,  32'h0BAD_F00D, 6'd0);
    issue(CMD_WRITE,  32'hCAFE_0001, 6'd0);   // dropped
    issue(CMD_RESIZE, 32'h0000_0000, 6'd1);   // one discard
    issue(CMD_READ,   32'h0000_0000, 6'd0);
    issue(CMD_READ,   32'h0000_0000, 6'd0);   // refused on empty

    // Random phases. The first four walk all mode combinations, the rest pick
    // at random. Each phase leans toward filling or draining.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      if (phase < 4) write_modes(phase[0], phase[1]);
      else write_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      gaps_on = (phase < 6);
      for (int n = 0; n < 26; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < write_pct[phase]) cmd = CMD_WRITE;
        else if (pick < 88) cmd = CMD_READ;
        else if (pick < 97) cmd = CMD_RESIZE;
        else cmd = CMD_NONE;
        // mostly small capacities so full is frequent, some large, some any code
        pick = $urandom_range(0, 99);
        if (pick < 50) nc = CNT_W'($urandom_range(1, 8));
        else if (pick < 85) nc = CNT_W'($urandom_range(9, 40));
        else nc = CNT_W'($urandom_range(0, 63));
        issue(cmd, $urandom, nc);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** ring_fifo_with_overflow_modes_top: PASSED **");
    end else begin
      $display("** ring_fifo_with_overflow_modes_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== ring_fifo_with_overflow_modes_top.f =====
rtl/rfo_pkg.sv
rtl/rfo_cell.sv
rtl/ring_fifo_with_overflow_modes_top.sv
sim/ring_fifo_with_overflow_modes_checker.sv
sim/ring_fifo_with_overflow_modes_top_test.sv
